// File: sv/array_list_engine_macros.svh
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, checked at every clock once out of reset
`define ALE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array list check failed");

// next-cycle implication
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array list check failed");

`endif

// File: sv/ale_pkg.sv
`timescale 1ns / 1ps
package ale_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int ACT_W     = 3;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 10;
    localparam int CNT_W     = 11;

    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FILTER  = 3'd4;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_REMOVE,
        OP_SEARCH,
        OP_REVERSE,
        OP_FILTER,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } cmd_t;

endpackage

// File: sv/ale_front.sv
`timescale 1ns / 1ps
module ale_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ale_pkg::ACT_W-1:0]        action,
    input  logic signed [ale_pkg::KEY_W-1:0] key_in,
    input  logic [ale_pkg::POS_W-1:0]        position,
    output logic                             q_valid,
    output ale_pkg::cmd_t                    q_cmd,
    input  logic                             q_pop
);

    ale_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    ale_pkg::cmd_t cmd_in;
    logic          push, pop;

    always_comb
    begin
        cmd_in.key = key_in;
        cmd_in.pos = position;
        case (action)
            ale_pkg::ACT_APPEND:  cmd_in.op = ale_pkg::OP_APPEND;
            ale_pkg::ACT_REMOVE:  cmd_in.op = ale_pkg::OP_REMOVE;
            ale_pkg::ACT_SEARCH:  cmd_in.op = ale_pkg::OP_SEARCH;
            ale_pkg::ACT_REVERSE: cmd_in.op = ale_pkg::OP_REVERSE;
            ale_pkg::ACT_FILTER:  cmd_in.op = ale_pkg::OP_FILTER;
            default:              cmd_in.op = ale_pkg::OP_NONE;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: sv/ale_back.sv
`timescale 1ns / 1ps
module ale_back
#(
    parameter int DEPTH = ale_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  ale_pkg::cmd_t                     q_cmd,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              ok,
    output logic signed [ale_pkg::KEY_W-1:0]  key_out,
    output logic [ale_pkg::CNT_W-1:0]         count,
    output logic                              empty_res
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (FW > ale_pkg::POS_W) ? FW : ale_pkg::POS_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_USE  = 6'b000100,
        S_RD2  = 6'b001000,
        S_USE2 = 6'b010000,
        S_WR   = 6'b100000
    } state_t;

    logic [ale_pkg::KEY_W-1:0] mem [DEPTH];
    logic [ale_pkg::KEY_W-1:0] rd_data_reg;

    state_t                    state_reg, state_next;
    ale_pkg::cmd_t             cmd_reg, cmd_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic [FW-1:0]             idx_reg, idx_next;
    logic [FW-1:0]             aux_reg, aux_next;
    logic [ale_pkg::KEY_W-1:0] tmp_reg, tmp_next;
    logic                      okw_reg, okw_next;
    logic [ale_pkg::KEY_W-1:0] kout_reg, kout_next;
    logic                      ov_reg, ov_next;
    logic                      ok_reg, ok_next;
    logic [ale_pkg::KEY_W-1:0] ko_reg, ko_next;
    logic [ale_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      emp_reg, emp_next;

    logic                      we;
    logic [AW-1:0]             waddr, raddr;
    logic [ale_pkg::KEY_W-1:0] wdata;
    logic                      done, out_free;
    logic [FW-1:0]             kept;

    assign out_free = !ov_reg || !out_stall;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && out_free;
    assign raddr    = (state_reg == S_RD2) ? aux_reg[AW-1:0] : idx_reg[AW-1:0];
    assign kept     = aux_reg + FW'(rd_data_reg[0]);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        aux_next   = aux_reg;
        tmp_next   = tmp_reg;
        okw_next   = okw_reg;
        kout_next  = kout_reg;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = rd_data_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next  = q_cmd;
                    idx_next  = '0;
                    aux_next  = '0;
                    okw_next  = 1'b0;
                    kout_next = '0;
                    case (q_cmd.op)
                        ale_pkg::OP_APPEND:
                        begin
                            done = 1'b1;
                            if (fill_reg < FW'(DEPTH))
                            begin
                                we        = 1'b1;
                                waddr     = fill_reg[AW-1:0];
                                wdata     = q_cmd.key;
                                fill_next = fill_reg + FW'(1);
                                okw_next  = 1'b1;
                            end
                        end
                        ale_pkg::OP_REMOVE:
                        begin
                            if (CW'(q_cmd.pos) < CW'(fill_reg))
                            begin
                                idx_next   = FW'(q_cmd.pos);
                                state_next = S_RD;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        ale_pkg::OP_SEARCH, ale_pkg::OP_FILTER:
                        begin
                            if (fill_reg != '0)
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        ale_pkg::OP_REVERSE:
                        begin
                            okw_next = (fill_reg != '0);
                            aux_next = fill_reg - FW'(1);
                            if (fill_reg > FW'(1))
                            begin
                                state_next = S_RD;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_USE;
            end
            S_USE:
            begin
                case (cmd_reg.op)
                    ale_pkg::OP_REMOVE:
                    begin
                        // first read is the removed key, later ones slide down by one
                        if (idx_reg == FW'(cmd_reg.pos))
                        begin
                            kout_next = rd_data_reg;
                        end
                        else
                        begin
                            we    = 1'b1;
                            waddr = AW'(idx_reg - FW'(1));
                        end
                        if (idx_reg + FW'(1) < fill_reg)
                        begin
                            idx_next   = idx_reg + FW'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            fill_next  = fill_reg - FW'(1);
                            okw_next   = 1'b1;
                            done       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ale_pkg::OP_SEARCH:
                    begin
                        if (rd_data_reg == cmd_reg.key)
                        begin
                            okw_next   = 1'b1;
                            done       = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (idx_reg + FW'(1) < fill_reg)
                        begin
                            idx_next   = idx_reg + FW'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            done       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ale_pkg::OP_FILTER:
                    begin
                        if (rd_data_reg[0])
                        begin
                            we    = 1'b1;
                            waddr = aux_reg[AW-1:0];
                        end
                        aux_next = kept;
                        if (idx_reg + FW'(1) < fill_reg)
                        begin
                            idx_next   = idx_reg + FW'(1);
                            state_next = S_RD;
                        end
                        else
                        begin
                            fill_next  = kept;
                            okw_next   = (kept != fill_reg);
                            done       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // reverse: hold the low entry while the high one is read
                        tmp_next   = rd_data_reg;
                        state_next = S_RD2;
                    end
                endcase
            end
            S_RD2:
            begin
                state_next = S_USE2;
            end
            S_USE2:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                state_next = S_WR;
            end
            S_WR:
            begin
                we    = 1'b1;
                waddr = aux_reg[AW-1:0];
                wdata = tmp_reg;
                if (idx_reg + FW'(2) < aux_reg)
                begin
                    idx_next   = idx_reg + FW'(1);
                    aux_next   = aux_reg - FW'(1);
                    state_next = S_RD;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ov_next  = ov_reg && out_stall;
        ok_next  = ok_reg;
        ko_next  = ko_reg;
        cnt_next = cnt_reg;
        emp_next = emp_reg;
        if (done)
        begin
            ov_next  = 1'b1;
            ok_next  = okw_next;
            ko_next  = kout_next;
            cnt_next = ale_pkg::CNT_W'(fill_next);
            emp_next = (fill_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        aux_reg  <= aux_next;
        tmp_reg  <= tmp_next;
        okw_reg  <= okw_next;
        kout_reg <= kout_next;
        ok_reg   <= ok_next;
        ko_reg   <= ko_next;
        cnt_reg  <= cnt_next;
        emp_reg  <= emp_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign out_valid = ov_reg;
    assign ok        = ok_reg;
    assign key_out   = ko_reg;
    assign count     = cnt_reg;
    assign empty_res = emp_reg;

endmodule

// File: sv/array_list_engine.sv
`timescale 1ns / 1ps
// array list of signed 32-bit keys, one action per input item, one result item per action
// input channel: in_valid / in_stall with action, key_in, position
// output channel: out_valid / out_stall with ok, key_out, count, empty_res
// a two-entry command queue sits between the input side and the list engine,
// so items are taken while the engine works or a result waits
// the engine has one write and one registered read port on the key store,
// every stored key visited is read, then used
// work per item, after the queue:
//   append writes one key, remove slides the keys after position down, search stops at the first match,
//   reverse swaps pairs from both ends, drop-even keeps only odd keys, others only report
// the shortest path from accept to out_valid runs through the queue slot and the output register
// the engine starts the next item only once the output register is free,
// so a stalled receiver holds the result and backs up the queue, then in_stall
// reset empties the list at once (count zero), no clearing pass is needed
module array_list_engine
#(
    parameter int DEPTH = ale_pkg::DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ale_pkg::ACT_W-1:0]        action,
    input  logic signed [ale_pkg::KEY_W-1:0] key_in,
    input  logic [ale_pkg::POS_W-1:0]        position,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             ok,
    output logic signed [ale_pkg::KEY_W-1:0] key_out,
    output logic [ale_pkg::CNT_W-1:0]        count,
    output logic                             empty_res
);

    logic          q_valid;
    logic          q_pop;
    ale_pkg::cmd_t q_cmd;

    ale_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .key_in   (key_in),
        .position (position),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    ale_back #(.DEPTH(DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .key_out   (key_out),
        .count     (count),
        .empty_res (empty_res)
    );

endmodule

// File: sv/ale_checker.sv
`timescale 1ns / 1ps
`include "array_list_engine_macros.svh"
module ale_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             ok,
    input logic signed [ale_pkg::KEY_W-1:0] key_out,
    input logic [ale_pkg::CNT_W-1:0]        count,
    input logic                             empty_res
);

    `ALE_ASSERT_NOW(empty_means_zero, out_valid && empty_res, count == '0)
    `ALE_ASSERT_NOW(fail_has_no_key, out_valid && !ok, key_out == '0)
    `ALE_ASSERT_NEXT(held_result, out_valid && out_stall, out_valid && $stable(count) && $stable(ok))

endmodule

bind array_list_engine ale_checker u_chk (.*);

// File: bench/array_list_engine_tb.sv
`timescale 1ns / 1ps
module array_list_engine_tb;
    import ale_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD_CYCLES = 700;
    localparam int DRAIN_CYCLES = 6000;
    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

    typedef struct {
        logic [ACT_W-1:0]        act;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
    } list_cmd_t;

    typedef struct {
        logic                    ok;
        logic signed [KEY_W-1:0] key_out;
        logic [CNT_W-1:0]        count;
        logic                    empty_res;
    } list_reply_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key_in;
    logic [POS_W-1:0]        position;
    logic                    out_valid;
    logic                    out_stall;
    logic                    ok;
    logic signed [KEY_W-1:0] key_out;
    logic [CNT_W-1:0]        count;
    logic                    empty_res;

    list_cmd_t               cmd_queue[$];
    list_reply_t             reply_queue[$];
    logic signed [KEY_W-1:0] plan_list[$];
    logic signed [KEY_W-1:0] model_list[$];

    int   send_idle_pct;
    int   recv_stall_pct;
    logic cmd_taken;
    logic long_hold;
    int   mismatches;
    int   quiet_cycles;
    event hold_start;

    array_list_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .key_in    (key_in),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .key_out   (key_out),
        .count     (count),
        .empty_res (empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // applies one action to a list and returns the reply it gives
    function automatic list_reply_t apply_action(ref logic signed [KEY_W-1:0] lst[$],
                                                 input list_cmd_t c);
        list_reply_t             r;
        logic signed [KEY_W-1:0] kept[$];
        logic signed [KEY_W-1:0] t;
        int                      lo;
        int                      hi;
        r.ok = 1'b0;
        r.key_out = '0;
        case (c.act)
            ACT_APPEND:
                if (lst.size() < LIST_DEPTH)
                begin
                    lst.push_back(c.key);
                    r.ok = 1'b1;
                end
            ACT_REMOVE:
                if (int'(c.pos) < lst.size())
                begin
                    r.key_out = lst[c.pos];
                    lst.delete(c.pos);
                    r.ok = 1'b1;
                end
            ACT_SEARCH:
                foreach (lst[i])
                    if (lst[i] == c.key)
                        r.ok = 1'b1;
            ACT_REVERSE:
                if (lst.size() != 0)
                begin
                    lo = 0;
                    hi = lst.size() - 1;
                    while (lo < hi)
                    begin
                        t = lst[lo];
                        lst[lo] = lst[hi];
                        lst[hi] = t;
                        lo++;
                        hi--;
                    end
                    r.ok = 1'b1;
                end
            ACT_FILTER:
            begin
                foreach (lst[i])
                    if (lst[i][0])
                        kept.push_back(lst[i]);
                if (kept.size() != lst.size())
                begin
                    lst = kept;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(lst.size());
        r.empty_res = (lst.size() == 0);
        return r;
    endfunction

    task automatic add_cmd(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] key,
                           input logic [POS_W-1:0] pos);
        list_cmd_t   c;
        list_reply_t r;
        c.act = act;
        c.key = key;
        c.pos = pos;
        r = apply_action(plan_list, c);
        cmd_queue.push_back(c);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return '0;
            3: return -1;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random(input int n);
        int r;
        int sz;
        repeat (n)
        begin
            r = $urandom_range(99);
            sz = plan_list.size();
            if (r < 38 && sz > 48)
                r = 40;
            if (r < 38)
                add_cmd(ACT_APPEND, pick_key(), POS_W'($urandom));
            else if (r < 58)
                add_cmd(ACT_REMOVE, $urandom, (sz > 0) ? POS_W'($urandom_range(sz - 1))
                                                       : POS_W'($urandom));
            else if (r < 76)
                add_cmd(ACT_SEARCH, (sz > 0 && $urandom_range(1)) ?
                        plan_list[$urandom_range(sz - 1)] : pick_key(), POS_W'($urandom));
            else if (r < 84)
                add_cmd(ACT_REVERSE, $urandom, POS_W'($urandom));
            else if (r < 90)
                add_cmd(ACT_FILTER, $urandom, POS_W'($urandom));
            else if (r < 95)
                add_cmd(ACT_W'($urandom_range(7)), $urandom, POS_W'($urandom));
            else
                add_cmd(ACT_REMOVE, $urandom, POS_W'($urandom_range(1023, sz)));
        end
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || in_valid || reply_queue.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            key_in <= '0;
            position <= '0;
        end
        else if (!in_valid || cmd_taken)
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                action <= cmd_queue[0].act;
                key_in <= cmd_queue[0].key;
                position <= cmd_queue[0].pos;
                in_valid <= 1'b1;
                void'(cmd_queue.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        long_hold = 1'b0;
        forever
        begin
            @(hold_start);
            @(negedge clk);
            long_hold <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clk);
            long_hold <= 1'b0;
        end
    end

    // accepted items feed the list model, accepted results are checked
    always @(posedge clk or negedge rst_n)
    begin
        list_cmd_t   c;
        list_reply_t r;
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            cmd_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                c.act = action;
                c.key = key_in;
                c.pos = position;
                reply_queue.push_back(apply_action(model_list, c));
            end
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: ok=%0d key_out=%0d count=%0d",
                                 ok, key_out, count);
                end
                else
                begin
                    r = reply_queue.pop_front();
                    if (ok !== r.ok || key_out !== r.key_out || count !== r.count ||
                        empty_res !== r.empty_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp ok=%0d key_out=%0d count=%0d empty=%0d",
                                     r.ok, r.key_out, r.count, r.empty_res,
                                     ", got ok=%0d key_out=%0d count=%0d empty=%0d",
                                     ok, key_out, count, empty_res);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list corner cases and unused codes, then a small list of extreme keys
        add_cmd(ACT_REMOVE, '0, '0);
        add_cmd(ACT_REVERSE, '0, '0);
        add_cmd(ACT_FILTER, '0, '0);
        add_cmd(ACT_SEARCH, '0, '0);
        add_cmd(ACT_SPARE_5, KEY_MAX, '1);
        add_cmd(ACT_APPEND, KEY_MAX, '0);
        add_cmd(ACT_REVERSE, '0, '0);
        add_cmd(ACT_APPEND, KEY_MIN, '0);
        add_cmd(ACT_APPEND, '0, '0);
        add_cmd(ACT_APPEND, -1, '0);
        add_cmd(ACT_APPEND, 32'sd2, '0);
        add_cmd(ACT_SEARCH, KEY_MIN, '0);
        add_cmd(ACT_SEARCH, 32'sd77, '0);
        add_cmd(ACT_SPARE_6, '0, '0);
        add_cmd(ACT_REMOVE, '0, 10'd5);
        add_cmd(ACT_REMOVE, '0, '1);
        add_cmd(ACT_REMOVE, '0, 10'd4);
        add_cmd(ACT_REVERSE, '0, '0);
        // negative odd keys count as odd
        add_cmd(ACT_FILTER, '0, '0);
        add_cmd(ACT_FILTER, '0, '0);
        add_cmd(ACT_SPARE_7, '1, '1);
        add_cmd(ACT_REMOVE, '0, '0);
        add_cmd(ACT_REMOVE, '0, '0);
        add_cmd(ACT_FILTER, '0, '0);
        wait_idle();

        add_random(150);
        wait_idle();
        send_idle_pct = 86;
        add_random(130);
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 86;
        add_random(130);
        wait_idle();
        send_idle_pct = 15;
        recv_stall_pct = 15;
        add_random(130);
        wait_idle();

        // receiver holds off while items keep coming, the block backs up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ->hold_start;
        add_random(40);
        wait_idle();

        recv_stall_pct = 15;
        send_idle_pct = 15;
        add_random(20);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reply_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
